[rtl/assert_macros.svh]
// Assertion macros used by the top level RTL file of the status LED pattern generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge while rst_ni is high.
`define SLPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clk_i edge, in reset too.
`define SLPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/slpg_pkg.sv]
// Package with the types, constants and lookup tables of the status LED pattern generator.
package slpg_pkg;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_SET    = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_OFF         = 3'd0,
    ST_IDLE        = 3'd1,
    ST_HOLDING     = 3'd2,
    ST_MOVING      = 3'd3,
    ST_HOMING      = 3'd4,
    ST_HOMING_DONE = 3'd5,
    ST_STALL       = 3'd6,
    ST_ERROR       = 3'd7
  } status_e;

  typedef enum logic {
    CFG_DARK_MODE = 1'b0,
    CFG_POWERDOWN = 1'b1
  } cfg_e;

  localparam int IDLE_PERIOD   = 5000;
  localparam int HOMING_PERIOD = 500;
  localparam int PULSE_HALF    = 250;
  localparam int FLASH_HALF    = 100;
  localparam int FLASH_END     = 600;
  localparam int LEVEL_FULL    = 32;
  localparam int HOLD_SCALE    = 262144;
  localparam int HOLD_DIV      = 12000;

  localparam logic [7:0] POWERDOWN_RESET = 8'd20;

  typedef logic [5:0] level_t;

  typedef struct packed {
    logic [31:0] ms;
    logic [12:0] ph_idle;
    logic [8:0]  ph_homing;
    logic        odd_flash;
  } time_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } color_t;

  typedef level_t     tri_tbl_t   [0:PULSE_HALF];
  typedef level_t     amber_tbl_t [0:LEVEL_FULL];
  typedef logic [12:0] hold_tbl_t [0:255];

  function automatic tri_tbl_t build_tri_tbl();
    tri_tbl_t t;
    for (int i = 0; i <= PULSE_HALF; i++) begin
      t[i] = 6'((i * LEVEL_FULL) / PULSE_HALF);
    end
    return t;
  endfunction

  function automatic amber_tbl_t build_amber_tbl();
    amber_tbl_t t;
    for (int i = 0; i <= LEVEL_FULL; i++) begin
      t[i] = 6'((i * 2) / 5);
    end
    return t;
  endfunction

  function automatic hold_tbl_t build_hold_tbl();
    hold_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 13'((i * HOLD_SCALE) / HOLD_DIV);
    end
    return t;
  endfunction

  localparam tri_tbl_t   TRI_TBL   = build_tri_tbl();
  localparam amber_tbl_t AMBER_TBL = build_amber_tbl();
  localparam hold_tbl_t  HOLD_TBL  = build_hold_tbl();

endpackage

[rtl/slpg_timer.sv]
// Millisecond counter in the current status with its running pattern phases.
module slpg_timer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  logic            clear_i,
  output slpg_pkg::time_t time_o
);

  logic [31:0] ms_q, ms_d;
  logic [12:0] ph_idle_q, ph_idle_d;
  logic [8:0]  ph_homing_q, ph_homing_d;
  logic [6:0]  ph_flash_q, ph_flash_d;
  logic        odd_q, odd_d;

  always_comb begin
    ms_d        = ms_q;
    ph_idle_d   = ph_idle_q;
    ph_homing_d = ph_homing_q;
    ph_flash_d  = ph_flash_q;
    odd_d       = odd_q;
    if (clear_i || (tick_i && (ms_q == '1))) begin
      ms_d        = '0;
      ph_idle_d   = '0;
      ph_homing_d = '0;
      ph_flash_d  = '0;
      odd_d       = 1'b0;
    end else if (tick_i) begin
      ms_d = ms_q + 32'd1;
      if (ph_idle_q == 13'(slpg_pkg::IDLE_PERIOD - 1)) begin
        ph_idle_d = '0;
      end else begin
        ph_idle_d = ph_idle_q + 13'd1;
      end
      if (ph_homing_q == 9'(slpg_pkg::HOMING_PERIOD - 1)) begin
        ph_homing_d = '0;
      end else begin
        ph_homing_d = ph_homing_q + 9'd1;
      end
      if (ph_flash_q == 7'(slpg_pkg::FLASH_HALF - 1)) begin
        ph_flash_d = '0;
        odd_d      = ~odd_q;
      end else begin
        ph_flash_d = ph_flash_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q        <= '0;
      ph_idle_q   <= '0;
      ph_homing_q <= '0;
      ph_flash_q  <= '0;
      odd_q       <= 1'b0;
    end else begin
      ms_q        <= ms_d;
      ph_idle_q   <= ph_idle_d;
      ph_homing_q <= ph_homing_d;
      ph_flash_q  <= ph_flash_d;
      odd_q       <= odd_d;
    end
  end

  assign time_o.ms        = ms_q;
  assign time_o.ph_idle   = ph_idle_q;
  assign time_o.ph_homing = ph_homing_q;
  assign time_o.odd_flash = odd_q;

endmodule

[rtl/slpg_pattern.sv]
// Combinational color pattern for the current status and elapsed time.
module slpg_pattern (
  input  slpg_pkg::status_e status_i,
  input  slpg_pkg::time_t   time_i,
  input  logic              dark_i,
  input  logic [12:0]       hold_ms_i,
  output slpg_pkg::color_t  color_o,
  output logic              to_holding_o
);

  logic [12:0]      phase;
  logic [7:0]       tri_idx;
  slpg_pkg::level_t tri_level;
  logic             flash_window;

  always_comb begin
    if (status_i == slpg_pkg::ST_IDLE) begin
      phase = time_i.ph_idle;
    end else begin
      phase = {4'd0, time_i.ph_homing};
    end
    if (phase < 13'(slpg_pkg::PULSE_HALF)) begin
      tri_idx = phase[7:0];
    end else if (phase < 13'(2 * slpg_pkg::PULSE_HALF)) begin
      tri_idx = 8'(9'(2 * slpg_pkg::PULSE_HALF) - phase[8:0]);
    end else begin
      tri_idx = '0;
    end
    tri_level = slpg_pkg::TRI_TBL[tri_idx];
  end

  assign flash_window = time_i.ms < 32'(slpg_pkg::FLASH_END);

  always_comb begin
    color_o      = '0;
    to_holding_o = 1'b0;
    if (!dark_i) begin
      unique case (status_i)
        slpg_pkg::ST_OFF: begin
        end
        slpg_pkg::ST_IDLE: begin
          color_o.red   = tri_level;
          color_o.green = slpg_pkg::AMBER_TBL[tri_level];
        end
        slpg_pkg::ST_HOLDING: begin
          color_o.green = 6'(slpg_pkg::LEVEL_FULL);
        end
        slpg_pkg::ST_MOVING: begin
          color_o.blue = 6'(slpg_pkg::LEVEL_FULL);
        end
        slpg_pkg::ST_HOMING: begin
          color_o.blue = tri_level;
        end
        slpg_pkg::ST_HOMING_DONE: begin
          if (!(flash_window && time_i.odd_flash)) begin
            color_o.green = 6'(slpg_pkg::LEVEL_FULL);
          end
          to_holding_o = !flash_window && (time_i.ms >= {19'd0, hold_ms_i});
        end
        slpg_pkg::ST_STALL: begin
          if (!time_i.odd_flash) begin
            color_o.red = 6'(slpg_pkg::LEVEL_FULL);
          end
        end
        slpg_pkg::ST_ERROR: begin
          color_o.red = 6'(slpg_pkg::LEVEL_FULL);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/status_led_pattern_generator.sv]
// Top level of the status LED pattern generator.
// Requests arrive on the s_axis channel: tuser carries the request kind (tick,
// update or set) and tdata the new status used by a set request. A tick adds
// one millisecond to the time in the current status, a set changes the status
// when the code differs and forces the next color out, and an update produces
// one result on the m_axis channel with the RGB levels, the status and a send
// flag in tuser. Ticks and sets produce no result.
// A request is captured in an input register and handled once the result
// register can take a new result; then the status, timer and color registers
// update and the result register loads, and the result is presented on m_axis
// until it is taken. One request is taken every cycle; the limit is the single
// result register. When the receiver holds m_axis_tready low with a result
// waiting, the next request waits in the input register and s_axis_tready
// drops until the result is taken. Reset clears the status to off, the time,
// the last color and the forced send, sets dark mode off and the powerdown
// setting to its default of 20. Configuration is to be written through
// cfg_we_i by the user only while no request is in flight; the block does not
// enforce it.
`include "assert_macros.svh"

module status_led_pattern_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] new_status
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [5:0] red, [11:6] green, [17:12] blue, [20:18] status
  output logic        m_axis_tuser    // [0] send_frame
);

  logic              dark_q;
  logic [12:0]       hold_ms_q;

  logic              in_valid_q;
  logic [1:0]        in_req_q;
  logic [2:0]        in_status_q;

  slpg_pkg::status_e status_q, status_d;
  slpg_pkg::color_t  last_q;
  logic              force_q;

  logic              out_valid_q, out_valid_d;
  slpg_pkg::color_t  out_color_q;
  slpg_pkg::status_e out_status_q;
  logic              out_send_q;

  logic              out_ready;
  logic              advance;
  logic              is_tick, is_update, is_set, set_change;
  logic              timer_clear;
  slpg_pkg::time_t   cur_time;
  slpg_pkg::color_t  color;
  logic              to_holding;
  logic              send;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign advance       = in_valid_q && out_ready;

  assign is_tick    = advance && (in_req_q == slpg_pkg::REQ_TICK);
  assign is_update  = advance && (in_req_q == slpg_pkg::REQ_UPDATE);
  assign is_set     = advance && (in_req_q == slpg_pkg::REQ_SET);
  assign set_change = is_set && (in_status_q != status_q);
  assign timer_clear = set_change || (is_update && to_holding);

  slpg_timer u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (is_tick),
    .clear_i (timer_clear),
    .time_o  (cur_time)
  );

  slpg_pattern u_pattern (
    .status_i     (status_q),
    .time_i       (cur_time),
    .dark_i       (dark_q),
    .hold_ms_i    (hold_ms_q),
    .color_o      (color),
    .to_holding_o (to_holding)
  );

  // Moving from homing done to holding forces the color out.
  assign send = force_q || to_holding || (color != last_q);

  always_comb begin
    status_d = status_q;
    if (set_change) begin
      status_d = slpg_pkg::status_e'(in_status_q);
    end else if (is_update && to_holding) begin
      status_d = slpg_pkg::ST_HOLDING;
    end
    out_valid_d = out_valid_q;
    if (is_update) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q      <= 1'b0;
      hold_ms_q   <= slpg_pkg::HOLD_TBL[slpg_pkg::POWERDOWN_RESET];
      in_valid_q  <= 1'b0;
      status_q    <= slpg_pkg::ST_OFF;
      last_q      <= '0;
      force_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (slpg_pkg::cfg_e'(cfg_addr_i))
          slpg_pkg::CFG_DARK_MODE: dark_q <= cfg_wdata_i[0];
          slpg_pkg::CFG_POWERDOWN: hold_ms_q <= slpg_pkg::HOLD_TBL[cfg_wdata_i];
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      status_q <= status_d;
      if (is_update) begin
        last_q  <= color;
        force_q <= 1'b0;
      end else if (set_change) begin
        force_q <= 1'b1;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q    <= s_axis_tuser;
      in_status_q <= s_axis_tdata[2:0];
    end
    if (is_update) begin
      out_color_q  <= color;
      out_status_q <= status_d;
      out_send_q   <= send;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_status_q, out_color_q.blue, out_color_q.green,
                          out_color_q.red};
  assign m_axis_tuser  = out_send_q;

  `SLPG_ASSERT(a_holding_move, (is_update && to_holding) |=> (status_q == slpg_pkg::ST_HOLDING) && m_axis_tuser && (cur_time.ms == 32'd0), "homing done did not move to holding with a forced send")
  `SLPG_ASSERT(a_set_forces, set_change |=> force_q && (cur_time.ms == 32'd0), "status change did not clear time and force a send")
  `SLPG_ASSERT(a_dark_black, (is_update && dark_q) |=> (m_axis_tdata[17:0] == 18'd0), "dark mode result is not black")
  `SLPG_ASSERT(a_phase_track, (cur_time.ms < 32'(slpg_pkg::HOMING_PERIOD)) |-> (cur_time.ph_homing == cur_time.ms[8:0]), "homing phase out of step with the timer")

endmodule

[test/slpg_checker.sv]
// Checker that predicts the LED pattern results from observed requests and compares them.
module slpg_checker
  import slpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [2:0] new_status
  input  logic [1:0]  s_tuser_i,   // [1:0] req_type
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,   // [5:0] red, [11:6] green, [17:12] blue, [20:18] status
  input  logic        m_tuser_i,   // [0] send_frame
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    level_t    red;
    level_t    green;
    level_t    blue;
    logic      send;
    status_e   status;
  } led_result_t;

  led_result_t led_results_q[$];

  logic        dark_mode;
  logic [7:0]  powerdown;
  status_e     cur_status;
  logic [31:0] ms_elapsed;
  logic [23:0] last_color;
  logic        force_send;
  int          fail_cnt;

  led_result_t want;
  led_result_t got;
  logic [23:0] color;
  logic [63:0] hold_ms;

  function automatic level_t triangle_level(input int unsigned phase);
    int unsigned v;
    v = 0;
    if (phase < PULSE_HALF) begin
      v = (phase * LEVEL_FULL) / PULSE_HALF;
    end else if (phase < 2 * PULSE_HALF) begin
      v = ((2 * PULSE_HALF - phase) * LEVEL_FULL) / PULSE_HALF;
    end
    return level_t'(v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_mode  = 1'b0;
      powerdown  = POWERDOWN_RESET;
      cur_status = ST_OFF;
      ms_elapsed = '0;
      last_color = '0;
      force_send = 1'b0;
      fail_cnt   = 0;
      led_results_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_addr_i))
          CFG_DARK_MODE: dark_mode = cfg_wdata_i[0];
          CFG_POWERDOWN: powerdown = cfg_wdata_i;
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        got.red    = m_tdata_i[5:0];
        got.green  = m_tdata_i[11:6];
        got.blue   = m_tdata_i[17:12];
        got.status = status_e'(m_tdata_i[20:18]);
        got.send   = m_tuser_i;
        if (led_results_q.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d", got.red, got.green,
                 got.blue);
          fail_cnt++;
        end else begin
          want = led_results_q.pop_front();
          if (got.red !== want.red) begin
            $error("red_level: expected %0d, actual %0d", want.red, got.red);
            fail_cnt++;
          end
          if (got.green !== want.green) begin
            $error("green_level: expected %0d, actual %0d", want.green, got.green);
            fail_cnt++;
          end
          if (got.blue !== want.blue) begin
            $error("blue_level: expected %0d, actual %0d", want.blue, got.blue);
            fail_cnt++;
          end
          if (got.send !== want.send) begin
            $error("send_frame: expected %0d, actual %0d", want.send, got.send);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $error("current_status: expected %0d, actual %0d", want.status, got.status);
            fail_cnt++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        case (s_tuser_i)
          REQ_TICK: ms_elapsed = ms_elapsed + 32'd1;
          REQ_SET: begin
            if (s_tdata_i[2:0] != cur_status) begin
              cur_status = status_e'(s_tdata_i[2:0]);
              ms_elapsed = '0;
              force_send = 1'b1;
            end
          end
          REQ_UPDATE: begin
            want.red   = '0;
            want.green = '0;
            want.blue  = '0;
            hold_ms    = (64'(powerdown) * HOLD_SCALE) / HOLD_DIV;
            if (!dark_mode) begin
              case (cur_status)
                ST_IDLE: begin
                  want.red   = triangle_level(ms_elapsed % IDLE_PERIOD);
                  want.green = (want.red * 2) / 5;
                end
                ST_HOLDING: want.green = LEVEL_FULL;
                ST_MOVING:  want.blue  = LEVEL_FULL;
                ST_HOMING:  want.blue  = triangle_level(ms_elapsed % HOMING_PERIOD);
                ST_HOMING_DONE: begin
                  if (ms_elapsed < FLASH_END) begin
                    if (ms_elapsed % (2 * FLASH_HALF) < FLASH_HALF) want.green = LEVEL_FULL;
                  end else if (64'(ms_elapsed) < hold_ms) begin
                    want.green = LEVEL_FULL;
                  end else begin
                    // The powerdown delay has run out: the block settles into holding.
                    cur_status = ST_HOLDING;
                    ms_elapsed = '0;
                    force_send = 1'b1;
                    want.green = LEVEL_FULL;
                  end
                end
                ST_STALL: begin
                  if (((ms_elapsed / FLASH_HALF) & 32'd1) == 32'd0) want.red = LEVEL_FULL;
                end
                ST_ERROR: want.red = LEVEL_FULL;
                default: ;
              endcase
            end
            color       = {2'b00, want.red, 2'b00, want.green, 2'b00, want.blue};
            want.send   = force_send || (color != last_color);
            want.status = cur_status;
            last_color  = color;
            force_send  = 1'b0;
            led_results_q.push_back(want);
          end
          default: ;
        endcase
      end

      errors_o  <= fail_cnt;
      pending_o <= led_results_q.size();
    end
  end

endmodule

[test/tb_status_led_pattern_generator.sv]
// Testbench top that drives requests and configuration into the LED pattern generator.
module tb_status_led_pattern_generator;
  import slpg_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT = 14;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLDOFF_CYCLES = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [7:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [2:0] new_status
  logic [1:0]  s_axis_tuser;   // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [5:0] red, [11:6] green, [17:12] blue, [20:18] status
  logic        m_axis_tuser;   // [0] send_frame

  int errors;
  int pending;
  int cyc = 0;
  int quiet_cnt = 0;
  logic no_idle = 1'b0;

  status_led_pattern_generator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  slpg_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $error("no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // Result side: random stalls, plus long hold-offs that back the block up.
  initial begin
    int holdoff;
    int holds;
    int next_hold;
    holdoff = 0;
    holds = 0;
    next_hold = 60;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff > 0) begin
        m_axis_tready <= 1'b0;
        holdoff--;
      end else if (holds < 2 && cyc >= next_hold && m_axis_tvalid) begin
        m_axis_tready <= 1'b0;
        holdoff = HOLDOFF_CYCLES - 1;
        holds++;
        next_hold = cyc + 300;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [2:0] st);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b00000, st};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_req(REQ_TICK, 3'($urandom_range(7)));
  endtask

  task automatic drain(input int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_config(input logic dark, input logic [7:0] pd);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_DARK_MODE;
    cfg_wdata_i <= {7'b0000000, dark};
    @(posedge clk_i);
    cfg_addr_i  <= CFG_POWERDOWN;
    cfg_wdata_i <= pd;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      tick_run($urandom_range(1, 12));
    end else if (pick < 75) begin
      push_req(REQ_UPDATE, 3'($urandom_range(7)));
    end else if (pick < 95) begin
      push_req(REQ_SET, 3'($urandom_range(7)));
    end else begin
      push_req(REQ_UNUSED, 3'($urandom_range(7)));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = CFG_DARK_MODE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_req(REQ_UPDATE, ST_OFF);
    push_req(REQ_SET, ST_OFF);
    push_req(REQ_UNUSED, ST_ERROR);
    push_req(REQ_UPDATE, ST_OFF);
    push_req(REQ_SET, ST_IDLE);
    push_req(REQ_UPDATE, ST_IDLE);
    tick_run(60);
    push_req(REQ_UPDATE, ST_IDLE);
    push_req(REQ_SET, ST_HOLDING);
    push_req(REQ_UPDATE, ST_HOLDING);
    push_req(REQ_SET, ST_MOVING);
    push_req(REQ_UPDATE, ST_MOVING);
    push_req(REQ_UPDATE, ST_MOVING);
    push_req(REQ_SET, ST_HOMING);
    tick_run(40);
    push_req(REQ_UPDATE, ST_HOMING);
    push_req(REQ_SET, ST_HOMING_DONE);
    tick_run(150);
    push_req(REQ_UPDATE, ST_HOMING_DONE);
    push_req(REQ_SET, ST_STALL);
    tick_run(100);
    push_req(REQ_UPDATE, ST_STALL);
    push_req(REQ_SET, ST_ERROR);
    push_req(REQ_UPDATE, ST_ERROR);

    for (int ph = 0; ph < 6; ph++) begin
      drain(4);
      case (ph)
        0: write_config(1'b1, 8'd20);
        1: write_config(1'b0, 8'd0);
        2: write_config(1'b0, 8'd255);
        3: write_config(1'b1, 8'd255);
        4: write_config(1'b0, 8'($urandom_range(255)));
        default: write_config(1'b0, 8'd1);
      endcase
      no_idle = (ph == 2) || (ph == 3);
      repeat (10) random_step();
    end
    no_idle = 1'b0;

    drain(10);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/slpg_pkg.sv
rtl/slpg_timer.sv
rtl/slpg_pattern.sv
rtl/status_led_pattern_generator.sv
test/slpg_checker.sv
test/tb_status_led_pattern_generator.sv
